// File: src/r11g11b10_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// r11g11b10_pkg
// Shared widths and channel conversion functions between single-precision
// floats and the packed R11G11B10 unsigned float word.
// ----------------------------------------------------------------------------
package r11g11b10_pkg;

	localparam int unsigned FLOAT_W = 32;
	localparam int unsigned ITEM_W  = 4 * FLOAT_W;

	localparam logic [7:0]  MIN_EXP8   = 8'd112;
	localparam logic [7:0]  MAX_EXP8   = 8'd142;
	localparam logic [7:0]  EXP_ALL1_8 = 8'hff;
	localparam logic [4:0]  EXP_ALL1_5 = 5'h1f;
	localparam logic [10:0] SAT_CODE11 = 11'h7bf;
	localparam logic [9:0]  SAT_CODE10 = 10'h3df;

	// float to 11-bit channel: 5-bit exponent, 6-bit mantissa
	function automatic logic [10:0] pack11(input logic [31:0] bits);
		logic [7:0] e;
		logic [7:0] d;
		e = bits[30:23];
		d = e - MIN_EXP8;
		if (bits[31] || (e < MIN_EXP8)) begin
			pack11 = '0;
		end else if (e > MAX_EXP8) begin
			pack11 = SAT_CODE11;
		end else begin
			pack11 = {d[4:0], bits[22:17]};
		end
	endfunction

	// float to 10-bit channel: 5-bit exponent, 5-bit mantissa
	function automatic logic [9:0] pack10(input logic [31:0] bits);
		logic [7:0] e;
		logic [7:0] d;
		e = bits[30:23];
		d = e - MIN_EXP8;
		if (bits[31] || (e < MIN_EXP8)) begin
			pack10 = '0;
		end else if (e > MAX_EXP8) begin
			pack10 = SAT_CODE10;
		end else begin
			pack10 = {d[4:0], bits[22:18]};
		end
	endfunction

	function automatic logic [7:0] rebias(input logic [4:0] x);
		if (x == EXP_ALL1_5) begin
			rebias = EXP_ALL1_8;
		end else begin
			rebias = {3'b000, x} + MIN_EXP8;
		end
	endfunction

	function automatic logic [31:0] unpack11(input logic [10:0] code);
		if (code[10:6] == 5'd0) begin
			unpack11 = '0;
		end else begin
			unpack11 = {1'b0, rebias(code[10:6]), code[5:0], 17'd0};
		end
	endfunction

	function automatic logic [31:0] unpack10(input logic [9:0] code);
		if (code[9:5] == 5'd0) begin
			unpack10 = '0;
		end else begin
			unpack10 = {1'b0, rebias(code[9:5]), code[4:0], 18'd0};
		end
	endfunction

endpackage
`default_nettype wire

// File: src/r11g11b10_conv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// r11g11b10_conv
// Combinational pack of three floats and unpack of one packed word.
// ----------------------------------------------------------------------------
module r11g11b10_conv (
	input  wire logic [r11g11b10_pkg::ITEM_W-1:0] item,   // red, green, blue, packed_word
	output logic      [r11g11b10_pkg::ITEM_W-1:0] result  // packed, red, green, blue
);

	logic [31:0] red_f;
	logic [31:0] green_f;
	logic [31:0] blue_f;
	logic [31:0] word;

	assign red_f   = item[31:0];
	assign green_f = item[63:32];
	assign blue_f  = item[95:64];
	assign word    = item[127:96];

	assign result[31:0] = {r11g11b10_pkg::pack10(blue_f),
	                       r11g11b10_pkg::pack11(green_f),
	                       r11g11b10_pkg::pack11(red_f)};
	assign result[63:32]   = r11g11b10_pkg::unpack11(word[10:0]);
	assign result[95:64]   = r11g11b10_pkg::unpack11(word[21:11]);
	assign result[127:96]  = r11g11b10_pkg::unpack10(word[31:22]);

endmodule
`default_nettype wire

// File: src/r11g11b10_float_pack_unpack_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// r11g11b10_float_pack_unpack_top
// Stream converter between three single-precision channels and R11G11B10.
// ----------------------------------------------------------------------------
// Each transaction is converted in both directions: the three floats are
// packed into one R11G11B10 word and the packed word on the same transaction
// is unpacked into three floats. The block takes one transaction per clock
// while the output side accepts; each result passes the input register, then
// the result register. Throughput is one per cycle, limited only by the result
// register draining when the output side stalls.
module r11g11b10_float_pack_unpack_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// red_float, green_float, blue_float, packed_word
	input  wire logic [127:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// packed_result, red_result, green_result, blue_result
	output logic      [127:0] m_axis_tdata
);

	logic                              valid_s1;
	logic [r11g11b10_pkg::ITEM_W-1:0] item_s1;
	logic                              valid_s2;
	logic [r11g11b10_pkg::ITEM_W-1:0] result_s2;
	logic [r11g11b10_pkg::ITEM_W-1:0] result_c;
	logic                              adv1;
	logic                              adv2;

	assign adv2          = !valid_s2 || m_axis_tready;
	assign adv1          = !valid_s1 || adv2;
	assign s_axis_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			item_s1 <= s_axis_tdata;
		end
		if (adv2) begin
			result_s2 <= result_c;
		end
	end

	r11g11b10_conv u_conv (
		.item   (item_s1),
		.result (result_c)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = result_s2;

	// an empty result register never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_axis_tready)
		else $error("input stalled with empty result register");

	// an accepted transaction reaches the input register
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> valid_s1)
		else $error("accepted transaction lost");

	// a queued item follows a delivered result at once
	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && valid_s1) |=> m_axis_tvalid)
		else $error("pipeline bubble after delivery");

	// packing saturates and never emits an infinity or NaN exponent
	a_no_inf_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[10:6] != r11g11b10_pkg::EXP_ALL1_5
			&& m_axis_tdata[21:17] != r11g11b10_pkg::EXP_ALL1_5
			&& m_axis_tdata[31:27] != r11g11b10_pkg::EXP_ALL1_5))
		else $error("packed exponent all ones");

endmodule
`default_nettype wire

// File: verif/tb_r11g11b10_float_pack_unpack_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_r11g11b10_float_pack_unpack_top
// Self-checking bench for the R11G11B10 float pack/unpack stream converter.
// ----------------------------------------------------------------------------
// Every transaction carries three single-precision channels and one packed
// word. An independent predictor packs the channels and unpacks the word; each
// output transaction is compared field by field with the oldest prediction.
// Directed corner cases come first, then randomised traffic with bursty input,
// patterned output stalls and one long output hold-off that backs up the pipe.
module tb_r11g11b10_float_pack_unpack_top;

	localparam int CLK_PERIOD  = 20;
	localparam int HOLD_CYCLES = 64;
	localparam int TAIL_CYCLES = 10;

	typedef struct packed {
		logic [31:0] word_in;
		logic [31:0] blue_in;
		logic [31:0] green_in;
		logic [31:0] red_in;
	} pixel_in_t;

	typedef struct packed {
		logic [31:0] blue_out;
		logic [31:0] green_out;
		logic [31:0] red_out;
		logic [31:0] word_out;
	} pixel_out_t;

	typedef enum int {
		RX_ALWAYS,
		RX_COIN,
		RX_PATTERN,
		RX_STARVED
	} rx_mode_t;

	logic         clk           = 1'b0;
	logic         arst_n        = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata  = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;

	pixel_out_t conversions_due[$];
	int         mismatch_count = 0;
	int         burst_left     = 0;
	bit         gaps_off       = 1'b0;
	bit         hold_req       = 1'b0;

	r11g11b10_float_pack_unpack_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// float channel to unsigned small float; the 10-bit code sits in bits 9..0
	function automatic logic [10:0] to_ufloat(input logic [31:0] f, input bit narrow);
		logic [7:0] e;
		logic [7:0] x;
		e = f[30:23];
		x = e - r11g11b10_pkg::MIN_EXP8;
		if (f[31] || (e < r11g11b10_pkg::MIN_EXP8))
			return '0;
		if (e > r11g11b10_pkg::MAX_EXP8)
			return narrow ? {1'b0, r11g11b10_pkg::SAT_CODE10} : r11g11b10_pkg::SAT_CODE11;
		return narrow ? {1'b0, x[4:0], f[22:18]} : {x[4:0], f[22:17]};
	endfunction

	// the 5-bit mantissa gets a zero below it so both widths share the top bit
	function automatic logic [31:0] from_ufloat(input logic [10:0] code, input bit narrow);
		logic [4:0] x;
		logic [5:0] f;
		logic [7:0] e;
		x = narrow ? code[9:5] : code[10:6];
		f = narrow ? {code[4:0], 1'b0} : code[5:0];
		if (x == 5'd0)
			return '0;
		e = (x == r11g11b10_pkg::EXP_ALL1_5) ? r11g11b10_pkg::EXP_ALL1_8
			: ({3'b000, x} + r11g11b10_pkg::MIN_EXP8);
		return {1'b0, e, f, 17'd0};
	endfunction

	function automatic pixel_out_t convert_pixel(input pixel_in_t p);
		pixel_out_t r;
		logic [10:0] pr;
		logic [10:0] pg;
		logic [10:0] pb;
		pr = to_ufloat(p.red_in, 1'b0);
		pg = to_ufloat(p.green_in, 1'b0);
		pb = to_ufloat(p.blue_in, 1'b1);
		r.word_out  = {pb[9:0], pg, pr};
		r.red_out   = from_ufloat(p.word_in[10:0], 1'b0);
		r.green_out = from_ufloat(p.word_in[21:11], 1'b0);
		r.blue_out  = from_ufloat({1'b0, p.word_in[31:22]}, 1'b1);
		return r;
	endfunction

	function automatic logic [31:0] rand_float();
		logic [7:0] e;
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: begin
				case ($urandom_range(0, 10))
					0: return 32'h0000_0000;
					1: return 32'h8000_0000;
					2: return 32'h7f80_0000;
					3: return 32'hff80_0000;
					4: return 32'h7fc0_0000;
					5: return 32'h0000_0001;
					6: return 32'h007f_ffff;
					7: return 32'h477f_ffff;
					8: return 32'h4780_0000;
					9: return 32'h3800_0000;
					default: return 32'h37ff_ffff;
				endcase
			end
			default: begin
				// exponents around the representable window, mostly positive
				e = 8'($urandom_range(104, 150));
				return {($urandom_range(0, 7) == 0), e, 23'($urandom)};
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
			mismatch_count++;
		end
	endfunction

	// offers one transaction, idling between bursts unless gaps are switched off
	task automatic push_pixel(input logic [31:0] r, input logic [31:0] g,
			input logic [31:0] b, input logic [31:0] w);
		pixel_in_t item;
		int gap;
		if (!gaps_off && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		if (burst_left > 0)
			burst_left--;
		item.red_in   = r;
		item.green_in = g;
		item.blue_in  = b;
		item.word_in  = w;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= item;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		conversions_due.push_back(convert_pixel(item));
	endtask

	// sign, zero, denormal, window edges and saturation on the pack side
	task automatic test_pack_corners();
		push_pixel(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, $urandom);
		push_pixel(32'h8000_0000, 32'hff80_0000, 32'hffc0_0000, $urandom);
		push_pixel(32'h0000_0001, 32'h007f_ffff, 32'h37ff_ffff, $urandom);
		push_pixel(32'h3800_0000, 32'h387f_ffff, 32'h3803_ffff, $urandom);
		push_pixel(32'h477f_ffff, 32'h4700_0000, 32'h477e_0000, $urandom);
		push_pixel(32'h4780_0000, 32'h7f80_0000, 32'h7fc0_0000, $urandom);
		push_pixel(32'h3f80_0000, 32'h4000_0000, 32'h3f00_0000, $urandom);
		push_pixel(32'hffff_ffff, 32'h7fff_ffff, 32'haaaa_aaaa, $urandom);
	endtask

	// exponent zero with live mantissa, smallest and largest finite, inf and nan
	task automatic test_unpack_corners();
		push_pixel(rand_float(), rand_float(), rand_float(), 32'h0000_0000);
		push_pixel(rand_float(), rand_float(), rand_float(), 32'h001f_f83f);
		push_pixel(rand_float(), rand_float(), rand_float(), 32'h0400_0840);
		push_pixel(rand_float(), rand_float(), rand_float(), 32'hf7df_effb);
		push_pixel(rand_float(), rand_float(), rand_float(), 32'hf83e_07c0);
		push_pixel(rand_float(), rand_float(), rand_float(), 32'hffff_ffff);
		push_pixel(rand_float(), rand_float(), rand_float(), 32'haaaa_aaaa);
		push_pixel(rand_float(), rand_float(), rand_float(), 32'h5555_5555);
	endtask

	task automatic test_random_pixels(input int count);
		repeat (count)
			push_pixel(rand_float(), rand_float(), rand_float(), $urandom);
	endtask

	// back-to-back input against a long output hold-off so the pipe fills
	task automatic test_output_backpressure();
		gaps_off = 1'b1;
		hold_req = 1'b1;
		repeat (40)
			push_pixel(rand_float(), rand_float(), rand_float(), $urandom);
		gaps_off = 1'b0;
	endtask

	// output side: segments of differing stall behaviour, plus the hold-off
	initial begin
		rx_mode_t mode;
		int seg_left;
		int hold_cnt;
		int phase;
		mode     = RX_ALWAYS;
		seg_left = 0;
		hold_cnt = 0;
		phase    = 0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				m_axis_tready <= 1'b0;
			end else if (hold_cnt > 0) begin
				hold_cnt--;
				m_axis_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_cnt = HOLD_CYCLES - 1;
				m_axis_tready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					mode     = rx_mode_t'($urandom_range(0, 3));
					seg_left = $urandom_range(20, 200);
				end
				seg_left--;
				phase++;
				case (mode)
					RX_ALWAYS:  m_axis_tready <= 1'b1;
					RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
					RX_PATTERN: m_axis_tready <= (phase % 4) != 0;
					default:    m_axis_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// sampled before this edge's updates, so no ordering hazard with the drivers
	always @(posedge clk) begin
		pixel_out_t due;
		pixel_out_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (conversions_due.size() == 0) begin
				$error("unexpected output transaction %h", m_axis_tdata);
				mismatch_count++;
			end else begin
				due = conversions_due.pop_front();
				check_field("packed_result", due.word_out, got.word_out);
				check_field("red_result", due.red_out, got.red_out);
				check_field("green_result", due.green_out, got.green_out);
				check_field("blue_result", due.blue_out, got.blue_out);
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pack_corners();
		test_unpack_corners();
		test_random_pixels(700);
		test_output_backpressure();
		test_random_pixels(700);
		s_axis_tvalid <= 1'b0;
		while (conversions_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && conversions_due.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout waiting for output transactions");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
